// File: src/pbf_pkg.sv
`timescale 1ns / 1ps
package pbf_pkg;
    localparam logic [1:0] REG_WIDTH_MODE = 2'd0;
    localparam logic [1:0] REG_FLOAT_MODE = 2'd1;
    localparam logic [1:0] REG_STEREO     = 2'd2;

    typedef struct packed {
        logic [1:0] width_mode;
        logic       float_mode;
        logic       stereo;
    } t_cfg;

    // assembled sample handed from the assembler to the converter
    typedef struct packed {
        logic [31:0] raw;
        logic [1:0]  top;
        logic        float_mode;
        logic        channel;
        logic        last;
    } t_sample;
endpackage

// File: src/pcm_bytes_to_float32.sv
`timescale 1ns / 1ps
// PCM byte stream to float32 converter. One byte is taken per cycle unless
// stalled; a sample leaves in the cycle after its final byte via a single output
// register that keeps taking bytes while a result waits unless it is stalled.
// Samples of 8/16/24/32 bits are scaled to [-1,1); float_mode passes raw words.
// Registers at paddr 0 (width_mode), 4 (float_mode), 8 (stereo).
module pcm_bytes_to_float32 import pbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sample_word,
    output logic        o_channel,
    output logic        o_last
);
    t_cfg        r_cfg;
    logic        take;
    logic        done;
    t_sample     smp;
    logic [31:0] word;
    logic        r_valid;
    logic [31:0] r_word;
    logic        r_chan;
    logic        r_last;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{width_mode: 2'd1, float_mode: 1'b0, stereo: 1'b0};
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_WIDTH_MODE: r_cfg.width_mode <= pwdata[1:0];
                REG_FLOAT_MODE: r_cfg.float_mode <= pwdata[0];
                REG_STEREO:     r_cfg.stereo     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WIDTH_MODE: prdata = {30'h0, r_cfg.width_mode};
            REG_FLOAT_MODE: prdata = {31'h0, r_cfg.float_mode};
            REG_STEREO:     prdata = {31'h0, r_cfg.stereo};
            default:        prdata = 32'h0;
        endcase
    end

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;

    pbf_assemble u_asm (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_take(take),
        .i_data_byte, .i_end_of_data, .o_done(done), .o_sample(smp)
    );

    pbf_convert u_cvt (.i_sample(smp), .o_word(word));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (take && done) begin
                r_valid <= 1'b1;
                r_word  <= word;
                r_chan  <= smp.channel;
                r_last  <= smp.last;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_sample_word = r_word;
    assign o_channel     = r_chan;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_word))
        else $error("result dropped under stall");
    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !r_cfg.stereo && $past(!r_cfg.stereo) |-> !o_channel)
        else $error("mono sample on right channel");
    a_nointake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> !take)
        else $error("item taken while stalled");
`endif
endmodule

// File: src/pbf_assemble.sv
`timescale 1ns / 1ps
module pbf_assemble import pbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_take,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    output logic        o_done,
    output t_sample     o_sample
);
    logic [23:0] r_acc;
    logic [1:0]  r_pos;
    logic        r_chan;
    logic [1:0]  top;
    logic [31:0] raw;
    logic [31:0] mask;

    assign top = i_cfg.float_mode ? 2'd3 : i_cfg.width_mode;
    assign o_done = (r_pos >= top);

    always_comb begin
        case (top)
            2'd0:    mask = 32'h0000_0000;
            2'd1:    mask = 32'h0000_00FF;
            2'd2:    mask = 32'h0000_FFFF;
            default: mask = 32'h00FF_FFFF;
        endcase
        raw = ({8'h00, r_acc} & mask) | ({24'h0, i_data_byte} << {top, 3'b000});
    end

    assign o_sample.raw        = raw;
    assign o_sample.top        = top;
    assign o_sample.float_mode = i_cfg.float_mode;
    assign o_sample.channel    = r_chan & i_cfg.stereo;
    assign o_sample.last       = i_end_of_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pos  <= '0;
            r_chan <= 1'b0;
        end else if (i_take) begin
            if (!o_done) begin
                case (r_pos)
                    2'd0:    r_acc[7:0]   <= i_data_byte;
                    2'd1:    r_acc[15:8]  <= i_data_byte;
                    default: r_acc[23:16] <= i_data_byte;
                endcase
                r_pos <= i_end_of_data ? 2'd0 : r_pos + 2'd1;
                if (i_end_of_data) r_chan <= 1'b0;
            end else begin
                r_pos  <= 2'd0;
                r_chan <= (i_end_of_data || !i_cfg.stereo) ? 1'b0 : ~r_chan;
            end
        end
    end
endmodule

// File: src/pbf_convert.sv
`timescale 1ns / 1ps
module pbf_convert import pbf_pkg::*; (
    input  t_sample     i_sample,
    output logic [31:0] o_word
);
    logic [4:0]  sbit;
    logic        neg;
    logic [32:0] mag;
    logic [5:0]  p;
    logic [32:0] q;
    logic [32:0] rem;
    logic [32:0] half;
    logic [5:0]  s;
    logic [7:0]  expo;
    logic [23:0] frac_m;

    always_comb begin
        sbit = {i_sample.top, 3'b111};
        if (i_sample.top == 2'd0) begin
            neg = i_sample.raw[7:0] < 8'h80;
            mag = neg ? 33'(8'h80 - i_sample.raw[7:0]) : 33'(i_sample.raw[7:0] - 8'h80);
        end else begin
            neg = i_sample.raw[sbit];
            // sign-extend from the sample's top bit, then take magnitude
            mag = neg ? 33'((33'h1 << (6'(sbit) + 6'd1)) - 33'(i_sample.raw))
                      : 33'(i_sample.raw);
        end
        p = 6'd0;
        for (int k = 0; k < 33; k++) begin
            if (mag[k]) p = 6'(k);
        end
        if (p > 6'd23) begin
            s    = p - 6'd23;
            rem  = mag & ((33'h1 << s) - 33'h1);
            half = 33'h1 << (s - 6'd1);
            q    = mag >> s;
            if (rem > half || (rem == half && q[0])) q = q + 33'h1;
            if (q[24]) begin
                q = q >> 1;
                p = p + 6'd1;
            end
        end else begin
            s    = 6'd0;
            rem  = '0;
            half = '0;
            q    = mag << (6'd23 - p);
        end
        expo   = 8'(8'd127 + 8'(p) - 8'(sbit));
        frac_m = q[23:0];
        if (i_sample.float_mode)
            o_word = i_sample.raw;
        else if (mag == 33'h0)
            o_word = 32'h0;
        else
            o_word = {neg, expo, frac_m[22:0]};
    end
endmodule
